// ===== rtl/core/pwm_pulse_width_median_capture_unit_macros.svh =====
// Assertion macros for the PWM pulse width median capture unit.
// Used by the top level only; no other dependencies.
`ifndef PWM_PULSE_WIDTH_MEDIAN_CAPTURE_UNIT_MACROS_SVH
`define PWM_PULSE_WIDTH_MEDIAN_CAPTURE_UNIT_MACROS_SVH

// Consequent must hold whenever the antecedent holds, outside reset.
`define PWMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold on the cycle after the antecedent.
`define PWMC_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pwmc_pkg.sv =====
// Shared types and constants of the PWM pulse width median capture unit.
// No dependencies.
`timescale 1ns / 1ps

package pwmc_pkg;

  localparam int CH_W      = 3;
  localparam int SEC_W     = 32;
  localparam int USEC_W    = 20;
  localparam int WIDTH_W   = 22;
  localparam int CNT_W     = 32;
  localparam int EN_W      = 8;

  localparam logic signed [WIDTH_W-1:0] USEC_PER_SEC = 22'sd1000000;

  localparam logic KIND_RISE = 1'b0;
  localparam logic KIND_FALL = 1'b1;

  // One measured width on its way from the front end to the filter
  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic signed [WIDTH_W-1:0] width;
  } pwmc_job_t;

endpackage

// ===== rtl/core/pwmc_front.sv =====
// Front end: edge classification, start timestamps and width measurement.
// Depends on pwmc_pkg.
`timescale 1ns / 1ps

module pwmc_front #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [pwmc_pkg::EN_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  logic                          in_kind,
  input  logic [pwmc_pkg::CH_W-1:0]     in_channel,
  input  logic [pwmc_pkg::SEC_W-1:0]    in_time_sec,
  input  logic [pwmc_pkg::USEC_W-1:0]   in_time_usec,
  input  logic                          q_full,
  output logic                          q_push,
  output pwmc_pkg::pwmc_job_t           q_job
);
  import pwmc_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [EN_W-1:0]   enable_r;
  logic [SEC_W-1:0]  start_sec_r  [CHANNELS];
  logic [USEC_W-1:0] start_usec_r [CHANNELS];
  logic [CHANNELS-1:0] pending_r;

  logic                      accept;
  logic                      chan_ok;
  logic [CW-1:0]             ch_idx;
  logic signed [WIDTH_W-1:0] diff;
  logic signed [WIDTH_W-1:0] width;

  assign accept  = in_push && !q_full;
  assign ch_idx  = CW'(in_channel);
  assign chan_ok = (32'(in_channel) < CHANNELS) && enable_r[in_channel];

  // Width: microsecond difference, plus one second when the second count moved on
  assign diff  = $signed({2'b00, in_time_usec}) - $signed({2'b00, start_usec_r[ch_idx]});
  assign width = (start_sec_r[ch_idx] < in_time_sec) ? diff + USEC_PER_SEC : diff;

  assign q_push        = accept && chan_ok && (in_kind == KIND_FALL) && pending_r[ch_idx];
  assign q_job.channel = in_channel;
  assign q_job.width   = width;

  // Channel enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
    end else if (cfg_valid) begin
      enable_r <= cfg_data;
    end
  end

  // Pending flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (accept && chan_ok) begin
      pending_r[ch_idx] <= (in_kind == KIND_RISE);
    end
  end

  // Start timestamps; only read behind a pending flag
  always_ff @(posedge clk) begin
    if (accept && chan_ok && (in_kind == KIND_RISE)) begin
      start_sec_r[ch_idx]  <= in_time_sec;
      start_usec_r[ch_idx] <= in_time_usec;
    end
  end

endmodule

// ===== rtl/core/pwmc_jobq.sv =====
// Two-entry queue of measured widths between front end and filter.
// Depends on pwmc_pkg.
`timescale 1ns / 1ps

module pwmc_jobq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pwmc_pkg::pwmc_job_t din,
  output logic                full,
  input  logic                pop,
  output pwmc_pkg::pwmc_job_t dout,
  output logic                empty
);
  import pwmc_pkg::*;

  pwmc_job_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = entry_r[rd_ptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= din;
  end

endmodule

// ===== rtl/core/pwmc_back.sv =====
// Back end: per-channel width window, rank-based median and result register.
// Depends on pwmc_pkg.
`timescale 1ns / 1ps

module pwmc_back #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  pwmc_pkg::pwmc_job_t               q_job,
  output logic                              q_pop,
  input  logic                              out_pop,
  output logic                              out_empty,
  output logic [pwmc_pkg::CH_W-1:0]         out_channel,
  output logic signed [pwmc_pkg::WIDTH_W-1:0] out_median_width,
  output logic signed [pwmc_pkg::WIDTH_W-1:0] out_raw_width,
  output logic [pwmc_pkg::CNT_W-1:0]        out_sample_total
);
  import pwmc_pkg::*;

  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LW    = $clog2(WINDOW + 1) + 1;
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(WINDOW + 1) + 1;
  localparam int MID   = WINDOW / 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RANK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r;

  logic signed [WIDTH_W-1:0] mem [DEPTH];
  logic signed [WIDTH_W-1:0] rdata_r;
  logic signed [WIDTH_W-1:0] win_r [WINDOW];

  logic [IW-1:0]  ptr_r  [CHANNELS];
  logic [LW-1:0]  fill_r [CHANNELS];
  logic [CNT_W-1:0] count_r [CHANNELS];

  logic [CW-1:0]             ch_r;
  logic signed [WIDTH_W-1:0] width_r;
  logic [IW-1:0]             pos_r;
  logic [LW-1:0]             fill_old_r;
  logic [CNT_W-1:0]          total_r;
  logic [LW-1:0]             ld_cnt_r;
  logic [IW-1:0]             cand_r;
  logic signed [WIDTH_W-1:0] med_r;
  logic                      out_valid_r;

  logic [CW-1:0]  job_ch;
  logic [IW-1:0]  job_ptr;
  logic [IW-1:0]  rd_idx;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic [IW-1:0]  cap_idx;
  logic [RW-1:0]  rank;
  logic           take_job;
  logic           emit_go;

  assign job_ch   = CW'(q_job.channel);
  assign job_ptr  = ptr_r[job_ch];
  assign take_job = (state_r == ST_IDLE) && !q_empty;
  assign q_pop    = take_job;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  assign rd_idx  = (ld_cnt_r < LW'(WINDOW)) ? ld_cnt_r[IW-1:0] : '0;
  assign rd_addr = AW'(int'(ch_r) * WINDOW + int'(rd_idx));
  assign wr_addr = AW'(int'(job_ch) * WINDOW + int'(job_ptr));
  assign cap_idx = IW'(ld_cnt_r - LW'(1));

  // Rank of the candidate; ties broken by position so every rank is unique
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((win_r[j] < win_r[cand_r]) ||
          ((win_r[j] == win_r[cand_r]) && (IW'(j) < cand_r))) begin
        rank = rank + RW'(1);
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: if (take_job) state_r <= ST_LOAD;
        ST_LOAD: if (ld_cnt_r == LW'(WINDOW)) state_r <= ST_RANK;
        ST_RANK: if (cand_r == IW'(WINDOW - 1)) state_r <= ST_EMIT;
        ST_EMIT: if (emit_go) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Per-channel ring pointer, fill level and sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_r[c]   <= '0;
        fill_r[c]  <= '0;
        count_r[c] <= '0;
      end
    end else if (take_job) begin
      ptr_r[job_ch]   <= (job_ptr == IW'(WINDOW - 1)) ? '0 : job_ptr + IW'(1);
      fill_r[job_ch]  <= (fill_r[job_ch] == LW'(WINDOW)) ? fill_r[job_ch]
                                                         : fill_r[job_ch] + LW'(1);
      count_r[job_ch] <= count_r[job_ch] + CNT_W'(1);
    end
  end

  // Job capture and step counters
  always_ff @(posedge clk) begin
    if (take_job) begin
      ch_r       <= job_ch;
      width_r    <= q_job.width;
      pos_r      <= job_ptr;
      fill_old_r <= fill_r[job_ch];
      total_r    <= count_r[job_ch] + CNT_W'(1);
      ld_cnt_r   <= '0;
      cand_r     <= '0;
    end else if (state_r == ST_LOAD) begin
      ld_cnt_r <= ld_cnt_r + LW'(1);
    end else if (state_r == ST_RANK) begin
      cand_r <= cand_r + IW'(1);
    end
  end

  // Window memory: one write per job, one registered read per load step
  always_ff @(posedge clk) begin
    if (take_job) mem[wr_addr] <= q_job.width;
    rdata_r <= mem[rd_addr];
  end

  // Local copy of the window; entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if ((state_r == ST_LOAD) && (ld_cnt_r != '0)) begin
      if (cap_idx == pos_r)
        win_r[cap_idx] <= width_r;
      else if (LW'(cap_idx) < fill_old_r)
        win_r[cap_idx] <= rdata_r;
      else
        win_r[cap_idx] <= '0;
    end
  end

  // Median latch
  always_ff @(posedge clk) begin
    if ((state_r == ST_RANK) && (rank == RW'(MID))) med_r <= win_r[cand_r];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_channel      <= CH_W'(ch_r);
      out_median_width <= med_r;
      out_raw_width    <= width_r;
      out_sample_total <= total_r;
    end
  end

endmodule

// ===== rtl/core/pwm_pulse_width_median_capture_unit.sv =====
// PWM capture unit: the filter works on one width at a time, taking it
// through WINDOW+1 memory reads and WINDOW rank steps before it can take
// the next width, which sets the throughput.
// Rising edges and ignored edges are handled in the front end alone.
// Synchronous active-low reset clears control state; window entries are
// treated as zero by per-channel fill counts, with no clearing pass.
`timescale 1ns / 1ps
`include "pwm_pulse_width_median_capture_unit_macros.svh"

module pwm_pulse_width_median_capture_unit #(
  parameter int CHANNELS = 8,
  parameter int WINDOW   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwmc_pkg::EN_W-1:0]           cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic                                in_kind,
  input  logic [pwmc_pkg::CH_W-1:0]           in_channel,
  input  logic [pwmc_pkg::SEC_W-1:0]          in_time_sec,
  input  logic [pwmc_pkg::USEC_W-1:0]         in_time_usec,
  output logic                                empty,
  input  logic                                pop,
  output logic [pwmc_pkg::CH_W-1:0]           out_channel,
  output logic signed [pwmc_pkg::WIDTH_W-1:0] out_median_width,
  output logic signed [pwmc_pkg::WIDTH_W-1:0] out_raw_width,
  output logic [pwmc_pkg::CNT_W-1:0]          out_sample_total
);
  import pwmc_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  pwmc_job_t q_in;
  pwmc_job_t q_out;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  pwmc_front #(.CHANNELS(CHANNELS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_push      (push),
    .in_kind      (in_kind),
    .in_channel   (in_channel),
    .in_time_sec  (in_time_sec),
    .in_time_usec (in_time_usec),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_in)
  );

  pwmc_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  pwmc_back #(.CHANNELS(CHANNELS), .WINDOW(WINDOW)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (q_out),
    .q_pop            (q_pop),
    .out_pop          (pop),
    .out_empty        (empty),
    .out_channel      (out_channel),
    .out_median_width (out_median_width),
    .out_raw_width    (out_raw_width),
    .out_sample_total (out_sample_total)
  );

  // Checks
  `PWMC_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, q_push, !q_full, "job queue overrun")
  `PWMC_ASSERT_IMPL(a_no_pop_when_empty, clk, rst_n, q_pop, !q_empty, "job queue underrun")
  `PWMC_ASSERT_NEXT(a_empty_after_reset, clk, !rst_n, empty, "result pending after reset")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the PWM pulse width median capture unit.
// Depends on pwmc_pkg and pwm_pulse_width_median_capture_unit; reads no files.
`timescale 1ns / 1ps

module tb;
  import pwmc_pkg::*;

  localparam int NCH      = 8;
  localparam int WIN      = 8;
  localparam int LATENCY  = 2 * WIN + 5;
  localparam int LIMIT    = 600000;

  typedef struct packed {
    logic [CH_W-1:0]           channel;
    logic signed [WIDTH_W-1:0] median;
    logic signed [WIDTH_W-1:0] raw;
    logic [CNT_W-1:0]          total;
  } capture_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [EN_W-1:0]            cfg_data = '0;
  logic                       push = 1'b0;
  logic                       full;
  logic                       in_kind = KIND_RISE;
  logic [CH_W-1:0]            in_channel = '0;
  logic [SEC_W-1:0]           in_time_sec = '0;
  logic [USEC_W-1:0]          in_time_usec = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [CH_W-1:0]            out_channel;
  logic signed [WIDTH_W-1:0]  out_median_width;
  logic signed [WIDTH_W-1:0]  out_raw_width;
  logic [CNT_W-1:0]           out_sample_total;

  // Shadow state of the capture unit
  logic [EN_W-1:0]            enable_mask;
  logic [SEC_W-1:0]           start_sec   [NCH];
  logic [USEC_W-1:0]          start_usec  [NCH];
  logic                       armed       [NCH];
  logic signed [WIDTH_W-1:0]  window      [NCH][WIN];
  logic [2:0]                 wr_ptr      [NCH];
  logic [CNT_W-1:0]           sample_cnt  [NCH];

  capture_t                   pending_captures[$];
  int                         errors = 0;
  int                         captures_seen = 0;
  int                         edges_sent = 0;
  int                         send_idle = 0;
  int                         recv_idle = 0;
  int                         hold_cycles = 0;
  int                         cycles = 0;

  pwm_pulse_width_median_capture_unit #(.CHANNELS(NCH), .WINDOW(WIN)) dut (.*);

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d captures outstanding", $time, pending_captures.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random pop, with a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checker
  always @(posedge clk) begin
    capture_t exp_c;
    if (rst_n && pop && !empty) begin
      captures_seen++;
      if (pending_captures.size() == 0) begin
        errors++;
        $display("%0t unexpected capture: expected none, got ch %0d med %0d raw %0d cnt %0d",
                 $time, out_channel, out_median_width, out_raw_width, out_sample_total);
      end else begin
        exp_c = pending_captures.pop_front();
        if (out_channel !== exp_c.channel) begin
          errors++;
          $display("%0t channel: expected %0d got %0d", $time, exp_c.channel, out_channel);
        end
        if (out_median_width !== exp_c.median) begin
          errors++;
          $display("%0t median: expected %0d got %0d", $time, exp_c.median, out_median_width);
        end
        if (out_raw_width !== exp_c.raw) begin
          errors++;
          $display("%0t raw width: expected %0d got %0d", $time, exp_c.raw, out_raw_width);
        end
        if (out_sample_total !== exp_c.total) begin
          errors++;
          $display("%0t sample count: expected %0d got %0d", $time, exp_c.total,
                   out_sample_total);
        end
      end
    end
  end

  // Rank WIN/2 of the channel window, ascending signed
  function automatic logic signed [WIDTH_W-1:0] window_median(int ch);
    logic signed [WIDTH_W-1:0] s [WIN];
    logic signed [WIDTH_W-1:0] t;
    for (int i = 0; i < WIN; i++) s[i] = window[ch][i];
    for (int i = 0; i < WIN; i++)
      for (int j = 0; j < WIN - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    return s[WIN/2];
  endfunction

  // Update shadow state for one accepted edge; queue a capture if one results
  function automatic void predict_capture(logic kind, logic [CH_W-1:0] ch,
                                          logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec);
    logic signed [WIDTH_W-1:0] w;
    capture_t c;
    if (!enable_mask[ch]) return;
    if (kind == KIND_RISE) begin
      start_sec[ch]  = sec;
      start_usec[ch] = usec;
      armed[ch]      = 1'b1;
      return;
    end
    if (!armed[ch]) return;
    armed[ch] = 1'b0;
    w = $signed({2'b00, usec}) - $signed({2'b00, start_usec[ch]});
    if (start_sec[ch] < sec) w = w + USEC_PER_SEC;
    window[ch][wr_ptr[ch]] = w;
    wr_ptr[ch]     = wr_ptr[ch] + 1'b1;
    sample_cnt[ch] = sample_cnt[ch] + 1;
    c.channel = ch;
    c.median  = window_median(ch);
    c.raw     = w;
    c.total   = sample_cnt[ch];
    pending_captures.push_back(c);
  endfunction

  // Send one edge transaction; entered and left just after a falling edge
  task automatic send_edge(logic kind, logic [CH_W-1:0] ch,
                           logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_kind      <= kind;
    in_channel   <= ch;
    in_time_sec  <= sec;
    in_time_usec <= usec;
    do @(posedge clk); while (full);
    predict_capture(kind, ch, sec, usec);
    edges_sent++;
    @(negedge clk);
  endtask

  // Drain outstanding captures and let the pipeline settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_captures.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_enable(logic [EN_W-1:0] mask);
    cfg_valid <= 1'b1;
    cfg_data  <= mask;
    do @(posedge clk); while (!cfg_ready);
    enable_mask = mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pulse(logic [CH_W-1:0] ch);
    logic [SEC_W-1:0]  s;
    logic [USEC_W-1:0] u0, u1;
    s  = $urandom;
    u0 = ($urandom_range(9) == 0) ? USEC_W'($urandom) : USEC_W'($urandom_range(999999));
    u1 = ($urandom_range(9) == 0) ? USEC_W'($urandom) : USEC_W'($urandom_range(999999));
    send_edge(KIND_RISE, ch, s, u0);
    case ($urandom_range(3))
      0: send_edge(KIND_FALL, ch, s, u1);
      1: send_edge(KIND_FALL, ch, s + 1, u1);
      2: send_edge(KIND_FALL, ch, s - 1, u1);
      default: send_edge(KIND_FALL, ch, $urandom, u1);
    endcase
  endtask

  // Extremes of the fields and the named corner cases
  task automatic test_directed();
    write_enable(8'hFF);
    send_edge(KIND_RISE, 3'd0, 32'd0, 20'd0);
    send_edge(KIND_FALL, 3'd0, 32'd0, 20'd999999);
    send_edge(KIND_FALL, 3'd0, 32'd0, 20'd5);                 // no start armed
    send_edge(KIND_RISE, 3'd1, 32'd7, 20'd100);
    send_edge(KIND_RISE, 3'd1, 32'd7, 20'd300);               // latest start wins
    send_edge(KIND_FALL, 3'd1, 32'd7, 20'd350);
    send_edge(KIND_RISE, 3'd2, 32'd9, 20'd999999);
    send_edge(KIND_FALL, 3'd2, 32'd10, 20'd0);                // second rolls over
    send_edge(KIND_RISE, 3'd3, 32'hFFFF_FFFF, 20'd500);
    send_edge(KIND_FALL, 3'd3, 32'd0, 20'd100);               // negative width
    send_edge(KIND_RISE, 3'd4, 32'd0, 20'd0);
    send_edge(KIND_FALL, 3'd4, 32'hFFFF_FFFF, 20'hFFFFF);     // widest
    send_edge(KIND_RISE, 3'd5, 32'd1, 20'hFFFFF);
    send_edge(KIND_FALL, 3'd5, 32'd1, 20'd0);                 // most negative
    for (int i = 0; i < 5; i++) begin                          // five pulses on channel 6
      send_edge(KIND_RISE, 3'd6, 32'd2, 20'd10);
      send_edge(KIND_FALL, 3'd6, 32'd2, 20'(20 + 37 * i));
    end
    wait_idle();
    write_enable(8'h7F);
    send_edge(KIND_RISE, 3'd7, 32'd3, 20'd0);                 // disabled channel
    send_edge(KIND_FALL, 3'd7, 32'd3, 20'd9);
    wait_idle();
  endtask

  // Mostly well-formed pulses on random channels under several enable masks, some noise
  task automatic test_random(int n, int s_idle, int r_idle);
    logic [EN_W-1:0] masks [4];
    masks = '{8'hFF, 8'h00, EN_W'($urandom), 8'h81};
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int m = 0; m < 4; m++) begin
      write_enable(masks[m]);
      for (int i = 0; i < n / 8; i++) begin
        if ($urandom_range(99) < 80) send_pulse(3'($urandom));
        else send_edge(1'($urandom), 3'($urandom), $urandom, USEC_W'($urandom));
      end
      wait_idle();
    end
  endtask

  // Receiver holds off while the sender keeps offering pulses
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    write_enable(8'hFF);
    hold_cycles = 1500;
    for (int i = 0; i < 40; i++) send_pulse(3'($urandom));
    wait_idle();
  endtask

  initial begin
    for (int c = 0; c < NCH; c++) begin
      start_sec[c] = '0; start_usec[c] = '0; armed[c] = 1'b0;
      wr_ptr[c] = '0; sample_cnt[c] = '0;
      for (int k = 0; k < WIN; k++) window[c][k] = '0;
    end
    enable_mask = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random(360, 38, 57);
    test_random(360, 57, 38);
    test_random(360, 0, 0);
    test_backpressure();

    $display("Sent %0d edges over several enable masks and idle mixes; checked %0d captures.",
             edges_sent, captures_seen);
    if (errors == 0 && pending_captures.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
